// ===== rtl/core/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Window register width and reset value
  localparam int unsigned WIN_BITS = 4;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 4'd4;

  // One packet never releases more than this many payloads
  localparam int unsigned MAX_DELIVER = 8;

  // Result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Controller sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_EMIT
  } st_t;

  // Result load strobe and flags from controller to output register
  typedef struct packed {
    logic ld;
    logic kind;
    logic last;
  } res_ctl_t;

endpackage

// ===== rtl/core/srr_pay_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pay_mem
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srr_pay_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/srr_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_out_reg
// Result holding register between the controller and the output stream.
// ----------------------------------------------------------------------------
module srr_out_reg
  import srr_pkg::*;
#(
  parameter int unsigned SEQ_BITS     = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  res_ctl_t                res,
  input  logic [SEQ_BITS-1:0]     res_ack,
  input  logic [PAYLOAD_BITS-1:0] res_pay,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_kind,
  output logic                    out_last,
  output logic [SEQ_BITS-1:0]     out_ack,
  output logic [PAYLOAD_BITS-1:0] out_pay
);

  // Slot can take a new result when empty or being drained
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the held result
  always_ff @(posedge clk) begin
    if (res.ld) begin
      out_kind <= res.kind;
      out_last <= res.last;
      out_ack  <= res_ack;
      out_pay  <= res_pay;
    end
  end

endmodule

// ===== rtl/core/srr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_ctrl
// Window bookkeeping, waiting flags and the in-order release sequencer.
// ----------------------------------------------------------------------------
module srr_ctrl
  import srr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH    = 8,
  parameter int unsigned SLOT_W       = 3,
  parameter int unsigned SEQ_BITS     = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [WIN_BITS-1:0]     cfg_wr_data,
  // packet request
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_ok,
  input  logic [SEQ_BITS-1:0]     in_seq,
  input  logic [PAYLOAD_BITS-1:0] in_pay,
  // payload buffer
  output logic                    mem_we,
  output logic [SLOT_W-1:0]       mem_waddr,
  output logic [PAYLOAD_BITS-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [SLOT_W-1:0]       mem_raddr,
  input  logic [PAYLOAD_BITS-1:0] mem_rdata,
  // result register
  input  logic                    res_free,
  output res_ctl_t                res,
  output logic [SEQ_BITS-1:0]     res_ack,
  output logic [PAYLOAD_BITS-1:0] res_pay
);

  // Widest usable window
  localparam int unsigned HALF  = 1 << (SEQ_BITS - 1);
  localparam int unsigned WM0   = (BUF_DEPTH < MAX_DELIVER) ? BUF_DEPTH : MAX_DELIVER;
  localparam int unsigned W_MAX = (WM0 < HALF) ? WM0 : HALF;
  localparam int unsigned CW    = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS;
  localparam int unsigned SW    = SLOT_W + 1;
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

  st_t                     state, state_next;
  logic [WIN_BITS-1:0]     window_size;
  logic [SEQ_BITS-1:0]     base;
  logic [SLOT_W-1:0]       base_slot;
  logic [BUF_DEPTH-1:0]    flags;
  logic [WIN_BITS-1:0]     cnt;
  logic                    pk_ok;
  logic [SEQ_BITS-1:0]     pk_seq;
  logic [PAYLOAD_BITS-1:0] pk_pay;

  logic [WIN_BITS-1:0] w_eff;
  logic [SEQ_BITS-1:0] d, d_neg;
  logic                in_win, in_old;
  logic [SW-1:0]       slot_sum;
  logic [SLOT_W-1:0]   slot, nxt_slot;
  logic                more;
  logic                set_flag, release_one;

  // Effective window: clamped to [1, W_MAX]
  always_comb begin
    if (window_size == '0) begin
      w_eff = WIN_BITS'(1);
    end else if (window_size > WIN_BITS'(W_MAX)) begin
      w_eff = WIN_BITS'(W_MAX);
    end else begin
      w_eff = window_size;
    end
  end

  // Window classification of the held packet
  assign d      = pk_seq - base;
  assign d_neg  = base - pk_seq;
  assign in_win = CW'(d) < CW'(w_eff);
  assign in_old = !in_win && (CW'(d_neg) <= CW'(w_eff));

  // Buffer slot = seq mod depth; seq below base means it wrapped past zero,
  // and then seq itself is smaller than the depth
  assign slot_sum = SW'(base_slot) + SW'(d);
  always_comb begin
    if (pk_seq < base) begin
      slot = SLOT_W'(pk_seq);
    end else if (slot_sum >= SW'(BUF_DEPTH)) begin
      slot = SLOT_W'(slot_sum - SW'(BUF_DEPTH));
    end else begin
      slot = SLOT_W'(slot_sum);
    end
  end

  // Slot of base + 1
  always_comb begin
    if (base == SEQ_MAX || base_slot == SLOT_W'(BUF_DEPTH - 1)) begin
      nxt_slot = '0;
    end else begin
      nxt_slot = base_slot + SLOT_W'(1);
    end
  end

  // Another release follows this one
  assign more = flags[nxt_slot] && (WIN_BITS'(cnt + WIN_BITS'(1)) < w_eff);

  // Next state and outputs
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    set_flag    = 1'b0;
    release_one = 1'b0;
    res         = '0;
    res_ack     = '0;
    res_pay     = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!pk_ok || !(in_win || in_old)) begin
          state_next = ST_IDLE;
        end else if (res_free) begin
          res.ld   = 1'b1;
          res.kind = KIND_ACK;
          res.last = !(in_win && d == '0);
          res_ack  = pk_seq;
          if (in_win && !flags[slot]) begin
            mem_we   = 1'b1;
            set_flag = 1'b1;
          end
          state_next = (in_win && d == '0) ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_free) begin
          res.ld      = 1'b1;
          res.kind    = KIND_DATA;
          res.last    = !more;
          res_pay     = mem_rdata;
          release_one = 1'b1;
          state_next  = more ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign mem_waddr = slot;
  assign mem_wdata = pk_pay;
  assign mem_raddr = base_slot;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  // Window base, waiting flags and release count
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      base_slot <= '0;
      flags     <= '0;
      cnt       <= '0;
    end else begin
      if (set_flag) begin
        flags[slot] <= 1'b1;
      end
      if (state == ST_EVAL) begin
        cnt <= '0;
      end
      if (release_one) begin
        flags[base_slot] <= 1'b0;
        base             <= base + SEQ_BITS'(1);
        base_slot        <= nxt_slot;
        cnt              <= cnt + WIN_BITS'(1);
      end
    end
  end

  // Held packet
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pk_ok  <= in_ok;
      pk_seq <= in_seq;
      pk_pay <= in_pay;
    end
  end

endmodule

// ===== rtl/core/selective_repeat_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective-repeat receiver: acknowledges, buffers and releases in order.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one packet per request: tuser = checksum flag, tdata =
//   sequence number and payload. m_axis carries results: tuser = kind
//   (0 acknowledgement, 1 delivery), tlast marks the final result of a
//   packet. A corrupt or out-of-range packet yields no result.
//   cfg_wr_en/cfg_wr_data write the window size; write only while idle.
// Sequence
//   A packet is taken in IDLE and classified in EVAL in the next cycle,
//   where its acknowledgement is loaded into the output register once
//   that register is free. Each released payload then takes one read of
//   the payload buffer in READ and one load of the output register in EMIT.
// Reset and stalls
//   rst clears the window base, the waiting flags and the output valid flag
//   and sets the window to 4; the payload buffer is not cleared. While
//   m_axis_tready is low the held result stays and the sequencer waits; a
//   new packet is still taken while the last result of the previous one
//   waits in the output register.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH    = 8,
  parameter int unsigned SEQ_BITS     = 8,
  parameter int unsigned PAYLOAD_BITS = 64,
  localparam int unsigned DW = ((SEQ_BITS + PAYLOAD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [WIN_BITS-1:0] cfg_wr_data,
  // packet stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DW-1:0]       s_axis_tdata,   // seq_number, payload
  input  logic                s_axis_tuser,   // checksum_ok
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DW-1:0]       m_axis_tdata,   // ack_number, delivered_payload
  output logic                m_axis_tuser,   // kind
  output logic                m_axis_tlast
);

  localparam int unsigned SLOT_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned PADW   = DW - SEQ_BITS - PAYLOAD_BITS;

  logic                    mem_we, mem_re, res_free;
  logic [SLOT_W-1:0]       mem_waddr, mem_raddr;
  logic [PAYLOAD_BITS-1:0] mem_wdata, mem_rdata, res_pay, out_pay;
  logic [SEQ_BITS-1:0]     res_ack, out_ack;
  res_ctl_t                res;

  // Controller
  srr_ctrl #(
    .BUF_DEPTH    (BUF_DEPTH),
    .SLOT_W       (SLOT_W),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_ok       (s_axis_tuser),
    .in_seq      (s_axis_tdata[SEQ_BITS-1:0]),
    .in_pay      (s_axis_tdata[SEQ_BITS +: PAYLOAD_BITS]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_free    (res_free),
    .res         (res),
    .res_ack     (res_ack),
    .res_pay     (res_pay)
  );

  // Payload buffer
  srr_pay_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (SLOT_W),
    .DW    (PAYLOAD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register
  srr_out_reg #(
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ack   (res_ack),
    .res_pay   (res_pay),
    .free      (res_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .out_ack   (out_ack),
    .out_pay   (out_pay)
  );

  // Pack result fields, zero padding on top
  generate
    if (PADW > 0) begin : g_pad
      assign m_axis_tdata = {{PADW{1'b0}}, out_pay, out_ack};
    end else begin : g_nopad
      assign m_axis_tdata = {out_pay, out_ack};
    end
  endgenerate

endmodule
